@@ src/wrp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wrp_pkg
// Shared constants for the two-buffer water ripple height field.
// ----------------------------------------------------------------------------
package wrp_pkg;

    localparam int DEF_MAX_WIDTH   = 256;
    localparam int DEF_MAX_HEIGHT  = 256;
    localparam int DEF_HEIGHT_BITS = 18;

    localparam int CFG_W       = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int OP_W        = 2;
    localparam int POS_W       = 8;
    localparam int HS_W        = 5;
    localparam int FIELD_BITS  = 18;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;
    localparam int CW          = 12;

    localparam int DAMP_MUL   = 31;
    localparam int DAMP_SHIFT = 6;
    localparam int DAMP_ROUND = 32;
    localparam int MIN_DIM    = 3;

    localparam logic [OP_W-1:0] OP_DROP = 2'd0;
    localparam logic [OP_W-1:0] OP_STEP = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

endpackage
`default_nettype wire

@@ src/water_ripple_height_field.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// water_ripple_height_field
// Two-buffer water ripple: drops, frame steps and height reads.
// ----------------------------------------------------------------------------
// After reset the block zeroes both height maps and accepts no transaction
// until that pass ends. A read passes through states RD1 and RD2, a drop walks
// the DROP state over each pixel it writes, and a frame step runs states PA,
// PB, PC and PD for each interior pixel: each pixel needs four neighbour reads
// from the current map, and that map has two read ports. The result register
// lets the next transaction enter while an earlier result still waits.
// ----------------------------------------------------------------------------
module water_ripple_height_field
    import wrp_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
    parameter int HEIGHT_BITS = DEF_HEIGHT_BITS
)
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    cfg_we,
    input  wire [CFG_IDX_W-1:0]    cfg_index,
    input  wire [CFG_W-1:0]        cfg_data,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire [IN_TDATA_W-1:0]   s_axis_tdata,  // pos_x, pos_y, half_size, drop_height
    input  wire [OP_W-1:0]         s_axis_tuser,  // op
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // height
    output logic [OP_W-1:0]        m_axis_tuser   // kind
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int FWW   = $clog2(MAX_WIDTH + 1);
    localparam int FHW   = $clog2(MAX_HEIGHT + 1);
    localparam int HB    = HEIGHT_BITS;
    localparam int WW    = (HB > FIELD_BITS ? HB : FIELD_BITS) + 1;
    localparam int TW    = HB + 3;
    localparam int MW2   = TW + 7;
    localparam logic signed [WW-1:0]  DH_MAX = WW'((64'sd1 <<< (HB - 1)) - 64'sd1);
    localparam logic signed [WW-1:0]  DH_MIN = -DH_MAX - WW'(1);
    localparam logic signed [MW2-1:0] NV_MAX = MW2'((64'sd1 <<< (HB - 1)) - 64'sd1);
    localparam logic signed [MW2-1:0] NV_MIN = -NV_MAX - MW2'(1);

    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_DROP = 4'd2;
    localparam logic [3:0] ST_PA   = 4'd3;
    localparam logic [3:0] ST_PB   = 4'd4;
    localparam logic [3:0] ST_PC   = 4'd5;
    localparam logic [3:0] ST_PD   = 4'd6;
    localparam logic [3:0] ST_RD1  = 4'd7;
    localparam logic [3:0] ST_RD2  = 4'd8;
    localparam logic [3:0] ST_FIN  = 4'd9;

    logic [3:0]              state_reg, state_next;
    logic [AW-1:0]           clr_reg, clr_next;
    logic                    cur_sel_reg, cur_sel_next;
    logic [FWW-1:0]          fw_reg, fw_next;
    logic [FHW-1:0]          fh_reg, fh_next;
    logic signed [CW-1:0]    cx_reg, cx_next, cy_reg, cy_next;
    logic signed [CW-1:0]    x0_reg, x0_next, x1_reg, x1_next;
    logic signed [CW-1:0]    y1_reg, y1_next;
    logic signed [HB-1:0]    dh_reg, dh_next;
    logic [AW-1:0]           rd_idx_reg, rd_idx_next;
    logic                    rd_ok_reg, rd_ok_next;
    logic [OP_W-1:0]         kind_reg, kind_next;
    logic signed [HB-1:0]    res_reg, res_next;
    logic signed [HB+1:0]    s1_reg, s1_next;
    logic signed [HB-1:0]    p_reg, p_next;
    logic signed [TW-1:0]    t_reg, t_next;
    logic                    ov_reg, ov_next;
    logic [OP_W-1:0]         ok_reg, ok_next;
    logic signed [HB-1:0]    oh_reg, oh_next;

    logic [HB-1:0]           mem0 [DEPTH];
    logic [HB-1:0]           mem1 [DEPTH];
    logic [HB-1:0]           q00, q01, q10, q11;
    logic [AW-1:0]           m0a0, m0a1, m1a0, m1a1, ca0, ca1, pa0, wa, pix;
    logic                    we0, we1;
    logic [HB-1:0]           wd0, wd1, wd_cur, wd_prev;
    logic                    w_cur, w_prev, w_both;
    logic signed [HB-1:0]    cq0, cq1, pq;

    logic                    in_acc, last_x, last_y, fin_go, step_go;
    logic [OP_W-1:0]         in_op;
    logic signed [CW-1:0]    px_s, py_s, hs_s, fw_s, fh_s, dx0, dx1, dy0, dy1;
    logic signed [WW-1:0]    dh_w, dh_sat;
    logic signed [MW2-1:0]   nv_w, nv_sh;
    logic signed [HB-1:0]    nv;
    logic [CFG_W-1:0]        cv;

    assign in_op  = s_axis_tuser;
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign step_go = in_acc && (in_op == OP_STEP);
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tuser  = ok_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - FIELD_BITS){1'b0}}, FIELD_BITS'(oh_reg)};

    assign pix = AW'(cy_reg[YW-1:0]) * AW'(MAX_WIDTH) + AW'(cx_reg[XW-1:0]);

    assign px_s = CW'(s_axis_tdata[POS_W-1:0]);
    assign py_s = CW'(s_axis_tdata[2*POS_W-1:POS_W]);
    assign hs_s = CW'(s_axis_tdata[2*POS_W+HS_W-1:2*POS_W]);
    assign fw_s = CW'(fw_reg);
    assign fh_s = CW'(fh_reg);
    assign dx0  = (px_s - hs_s < CW'(1)) ? CW'(1) : px_s - hs_s;
    assign dy0  = (py_s - hs_s < CW'(1)) ? CW'(1) : py_s - hs_s;
    assign dx1  = (px_s + hs_s - CW'(1) > fw_s - CW'(2)) ? fw_s - CW'(2)
                                                         : px_s + hs_s - CW'(1);
    assign dy1  = (py_s + hs_s - CW'(1) > fh_s - CW'(2)) ? fh_s - CW'(2)
                                                         : py_s + hs_s - CW'(1);
    assign dh_w = WW'($signed(s_axis_tdata[2*POS_W+HS_W+FIELD_BITS-1:2*POS_W+HS_W]));
    assign dh_sat = (dh_w > DH_MAX) ? DH_MAX : (dh_w < DH_MIN) ? DH_MIN : dh_w;

    assign cq0 = $signed(cur_sel_reg ? q10 : q00);
    assign cq1 = $signed(cur_sel_reg ? q11 : q01);
    assign pq  = $signed(cur_sel_reg ? q00 : q10);

    assign nv_w  = MW2'(t_reg) * MW2'(DAMP_MUL) + MW2'(DAMP_ROUND);
    assign nv_sh = nv_w >>> DAMP_SHIFT;
    assign nv    = (nv_sh > NV_MAX) ? HB'(NV_MAX) : (nv_sh < NV_MIN) ? HB'(NV_MIN)
                                                                      : HB'(nv_sh);

    assign last_x = (cx_reg == x1_reg);
    assign last_y = (cy_reg == y1_reg);
    assign fin_go = !ov_reg || m_axis_tready;
    assign cv     = cfg_data;

    always_comb
    begin
        ca0 = pix;
        ca1 = pix;
        pa0 = pix;
        case (state_reg)
            ST_PA:
            begin
                ca0 = pix - AW'(1);
                ca1 = pix + AW'(1);
            end
            ST_PB:
            begin
                ca0 = pix - AW'(MAX_WIDTH);
                ca1 = pix + AW'(MAX_WIDTH);
            end
            ST_RD1:
            begin
                ca0 = rd_idx_reg;
            end
            default:
            begin
                ca0 = pix;
            end
        endcase
        m0a0 = cur_sel_reg ? pa0 : ca0;
        m1a0 = cur_sel_reg ? ca0 : pa0;
        m0a1 = ca1;
        m1a1 = ca1;

        w_both  = (state_reg == ST_CLR);
        w_cur   = (state_reg == ST_DROP);
        w_prev  = (state_reg == ST_PD);
        wd_cur  = dh_reg;
        wd_prev = nv;
        wa      = w_both ? clr_reg : pix;
        we0 = w_both || (w_cur && !cur_sel_reg) || (w_prev && cur_sel_reg);
        we1 = w_both || (w_cur && cur_sel_reg) || (w_prev && !cur_sel_reg);
        wd0 = w_both ? '0 : (cur_sel_reg ? wd_prev : wd_cur);
        wd1 = w_both ? '0 : (cur_sel_reg ? wd_cur : wd_prev);
    end

    always_ff @(posedge clk)
    begin
        if (we0)
        begin
            mem0[wa] <= wd0;
        end
        q00 <= mem0[m0a0];
        q01 <= mem0[m0a1];
    end

    always_ff @(posedge clk)
    begin
        if (we1)
        begin
            mem1[wa] <= wd1;
        end
        q10 <= mem1[m1a0];
        q11 <= mem1[m1a1];
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        cur_sel_next = cur_sel_reg;
        fw_next      = fw_reg;
        fh_next      = fh_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        x0_next      = x0_reg;
        x1_next      = x1_reg;
        y1_next      = y1_reg;
        dh_next      = dh_reg;
        rd_idx_next  = rd_idx_reg;
        rd_ok_next   = rd_ok_reg;
        kind_next    = kind_reg;
        res_next     = res_reg;
        s1_next      = s1_reg;
        p_next       = p_reg;
        t_next       = t_reg;
        ov_next      = ov_reg && !m_axis_tready;
        ok_next      = ok_reg;
        oh_next      = oh_reg;

        if (cfg_we)
        begin
            if (cfg_index == REG_FRAME_WIDTH)
            begin
                fw_next = (cv < CFG_W'(MIN_DIM)) ? FWW'(MIN_DIM)
                        : (32'(cv) > MAX_WIDTH) ? FWW'(MAX_WIDTH) : FWW'(cv);
            end
            else if (cfg_index == REG_FRAME_HEIGHT)
            begin
                fh_next = (cv < CFG_W'(MIN_DIM)) ? FHW'(MIN_DIM)
                        : (32'(cv) > MAX_HEIGHT) ? FHW'(MAX_HEIGHT) : FHW'(cv);
            end
        end

        case (state_reg)
            ST_CLR:
            begin
                clr_next = clr_reg + AW'(1);
                if (32'(clr_reg) == DEPTH - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    kind_next = in_op;
                    res_next  = '0;
                    case (in_op)
                        OP_DROP:
                        begin
                            x0_next = dx0;
                            x1_next = dx1;
                            y1_next = dy1;
                            cx_next = dx0;
                            cy_next = dy0;
                            dh_next = HB'(dh_sat);
                            state_next = (dx0 > dx1 || dy0 > dy1) ? ST_FIN : ST_DROP;
                        end
                        OP_STEP:
                        begin
                            cur_sel_next = !cur_sel_reg;
                            x0_next = CW'(1);
                            x1_next = fw_s - CW'(2);
                            y1_next = fh_s - CW'(2);
                            cx_next = CW'(1);
                            cy_next = CW'(1);
                            state_next = ST_PA;
                        end
                        OP_READ:
                        begin
                            rd_idx_next = AW'(py_s) * AW'(MAX_WIDTH) + AW'(px_s);
                            rd_ok_next  = (px_s >= CW'(1)) && (py_s >= CW'(1)) &&
                                          (px_s + CW'(1) < fw_s) && (py_s + CW'(1) < fh_s);
                            state_next  = ST_RD1;
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_DROP, ST_PD:
            begin
                state_next = (state_reg == ST_PD) ? ST_PA : ST_DROP;
                if (last_x)
                begin
                    cx_next = x0_reg;
                    cy_next = cy_reg + CW'(1);
                    if (last_y)
                    begin
                        state_next = ST_FIN;
                    end
                end
                else
                begin
                    cx_next = cx_reg + CW'(1);
                end
            end
            ST_PA:
            begin
                state_next = ST_PB;
            end
            ST_PB:
            begin
                s1_next    = (HB+2)'(cq0) + (HB+2)'(cq1);
                p_next     = pq;
                state_next = ST_PC;
            end
            ST_PC:
            begin
                t_next = TW'(s1_reg) + TW'(cq0) + TW'(cq1) - (TW'(p_reg) <<< 1);
                state_next = ST_PD;
            end
            ST_RD1:
            begin
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                res_next   = rd_ok_reg ? cq0 : '0;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    ov_next    = 1'b1;
                    ok_next    = kind_reg;
                    oh_next    = res_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLR;
            clr_reg     <= '0;
            cur_sel_reg <= 1'b0;
            fw_reg      <= FWW'(MAX_WIDTH < 256 ? MAX_WIDTH : 256);
            fh_reg      <= FHW'(MAX_HEIGHT < 256 ? MAX_HEIGHT : 256);
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            cur_sel_reg <= cur_sel_next;
            fw_reg      <= fw_next;
            fh_reg      <= fh_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        x0_reg     <= x0_next;
        x1_reg     <= x1_next;
        y1_reg     <= y1_next;
        dh_reg     <= dh_next;
        rd_idx_reg <= rd_idx_next;
        rd_ok_reg  <= rd_ok_next;
        kind_reg   <= kind_next;
        res_reg    <= res_next;
        s1_reg     <= s1_next;
        p_reg      <= p_next;
        t_reg      <= t_next;
        ok_reg     <= ok_next;
        oh_reg     <= oh_next;
    end

    a_sel_swap: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(step_go) |-> $stable(cur_sel_reg))
        else $error("map roles changed without a step");

    a_step_interior: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PD) |-> (cx_reg >= CW'(1) && cy_reg >= CW'(1) &&
                                  cx_reg <= fw_s - CW'(2) && cy_reg <= fh_s - CW'(2)))
        else $error("step wrote a border pixel");

    a_drop_interior: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DROP) |-> (cx_reg >= CW'(1) && cy_reg >= CW'(1) &&
                                    cx_reg <= fw_s - CW'(2) && cy_reg <= fh_s - CW'(2)))
        else $error("drop wrote a border pixel");

endmodule
`default_nettype wire
